>>> hdl/rid_pkg.sv
// Package with the shared types and constants of the RMS image difference block.
package rid_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = 17;
  localparam int SQ_W = 34;
  localparam int RMS_W = 17;
  localparam int TOTAL_W = 25;
  localparam int MAX_PIXELS_LOG2_DEF = 24;

  // Iteration counts of the lane dividers, the mean divider and the square root.
  localparam int NORM_STEPS = 17;
  localparam int MEAN_STEPS = 33;
  localparam int ROOT_STEPS = 17;

  // Configuration register indexes.
  localparam logic CFG_MAX_A = 1'b0;
  localparam logic CFG_MAX_B = 1'b1;

  localparam logic [SAMPLE_W-1:0] MAX_RESET = 16'd255;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_a;
    logic [SAMPLE_W-1:0] green_a;
    logic [SAMPLE_W-1:0] blue_a;
    logic [SAMPLE_W-1:0] red_b;
    logic [SAMPLE_W-1:0] green_b;
    logic [SAMPLE_W-1:0] blue_b;
    logic                last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [RMS_W-1:0]   rms_diff;
    logic [TOTAL_W-1:0] pixel_total;
  } out_item_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic step;
    logic square;
  } lane_ctrl_t;

endpackage

>>> hdl/rms_image_difference_top.sv
// Top level of the RMS image difference block: sequencer, three lanes and the merge stage.
//
// Pixel pairs enter on the in channel (in_valid, in_ready, in_data) one transaction
// at a time. Each pair passes through one load step, 17 steps of the lane dividers
// that normalize the six samples, one square step and one merge of the three
// squared differences into the running sum; the per-sample division is the
// longest part. A pair with last_pixel set then starts the final unit, which runs
// 33 steps of mean division and 17 steps of square root, after which one
// result transaction (rms_diff, pixel_total) is offered on the out channel.
// The output register lets the block take the next image's pixels while the
// result waits; if a new result is ready before the receiver took the old one,
// the block holds and accepts nothing until out_ready is seen.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// make them only while the block is idle, which the block itself does not enforce.
// Synchronous reset rst clears sum, count and out_valid and sets both maxima to 255.
module rms_image_difference_top #(
  parameter int MAX_PIXELS_LOG2 = rid_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rid_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rid_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rid_pkg::SAMPLE_W-1:0]  cfg_data
);

  localparam int SUMW = MAX_PIXELS_LOG2 + 34;
  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam int SQW = rid_pkg::SQ_W;
  localparam logic [CW-1:0] LIMIT = CW'(1) << MAX_PIXELS_LOG2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                   state;
  logic [4:0]                   step_cnt;
  logic [rid_pkg::SAMPLE_W-1:0] max_a;
  logic [rid_pkg::SAMPLE_W-1:0] max_b;
  logic [SUMW-1:0]              sum;
  logic [CW-1:0]                count;
  logic                         last;
  logic [CW-1:0]                total;

  rid_pkg::lane_ctrl_t          ctrl;
  logic [SQW-1:0]               sq_r;
  logic [SQW-1:0]               sq_g;
  logic [SQW-1:0]               sq_b;
  logic                         root_start;
  logic                         root_done;
  logic [rid_pkg::RMS_W-1:0]    root;
  logic [SUMW-1:0]              sum_next;
  logic [CW-1:0]                count_next;
  logic [CW+rid_pkg::TOTAL_W-1:0] total_ext;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctrl.load = in_valid && in_ready;
    ctrl.step = (state == S_DIV);
    ctrl.square = (state == S_SQ);
    root_start = (state == S_ACC) && last;
    if (count < LIMIT) begin
      sum_next = sum + SUMW'(sq_r) + SUMW'(sq_g) + SUMW'(sq_b);
      count_next = count + CW'(1);
    end else begin
      sum_next = sum;
      count_next = count;
    end
    total_ext = {{rid_pkg::TOTAL_W{1'b0}}, total};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_a <= rid_pkg::MAX_RESET;
      max_b <= rid_pkg::MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rid_pkg::CFG_MAX_A: max_a <= cfg_data;
        rid_pkg::CFG_MAX_B: max_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lanes, one per color channel.
  rid_lane u_lane_r (
    .clk(clk), .ctrl(ctrl), .sample_a(in_data.red_a), .sample_b(in_data.red_b),
    .max_a(max_a), .max_b(max_b), .sq(sq_r)
  );
  rid_lane u_lane_g (
    .clk(clk), .ctrl(ctrl), .sample_a(in_data.green_a), .sample_b(in_data.green_b),
    .max_a(max_a), .max_b(max_b), .sq(sq_g)
  );
  rid_lane u_lane_b (
    .clk(clk), .ctrl(ctrl), .sample_a(in_data.blue_a), .sample_b(in_data.blue_b),
    .max_a(max_a), .max_b(max_b), .sq(sq_b)
  );

  rid_root #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_root (
    .clk(clk), .rst(rst), .start(root_start), .sum(sum_next), .count(count_next),
    .done(root_done), .root(root)
  );

  // Sequencer and merge of the lane results into the running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_cnt <= '0;
      sum <= '0;
      count <= '0;
      last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output stage sets out_valid itself while a result is being loaded.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last <= in_data.last_pixel;
            step_cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_cnt == 5'(rid_pkg::NORM_STEPS - 1)) begin
            state <= S_SQ;
          end else begin
            step_cnt <= step_cnt + 5'd1;
          end
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          if (last) begin
            total <= count_next;
            sum <= '0;
            count <= '0;
            state <= S_ROOT;
          end else begin
            sum <= sum_next;
            count <= count_next;
            state <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.rms_diff <= root;
            out_data.pixel_total <= total_ext[rid_pkg::TOTAL_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The count never passes its saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst) count <= LIMIT)
    else $error("pixel count above limit");

  // The final unit only reports completion while the sequencer waits for it.
  a_root_done: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("root done outside wait state");

  // A merge of a marked pixel always hands off to the final unit next cycle.
  a_last_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && last) |=> (state == S_ROOT && sum == '0 && count == '0))
    else $error("last pixel not handed to final unit");

  // A fresh result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule

>>> hdl/rid_lane.sv
// One color channel lane: normalizes both samples and squares their difference.
module rid_lane (
  input  logic                          clk,
  input  rid_pkg::lane_ctrl_t           ctrl,
  input  logic [rid_pkg::SAMPLE_W-1:0]  sample_a,
  input  logic [rid_pkg::SAMPLE_W-1:0]  sample_b,
  input  logic [rid_pkg::SAMPLE_W-1:0]  max_a,
  input  logic [rid_pkg::SAMPLE_W-1:0]  max_b,
  output logic [rid_pkg::SQ_W-1:0]      sq
);

  localparam int SW = rid_pkg::SAMPLE_W;
  localparam int FW = rid_pkg::FRAC_W;

  logic [SW-1:0] div_a;
  logic [SW-1:0] div_b;
  logic [SW-1:0] rem_a;
  logic [SW-1:0] rem_b;
  logic [FW-1:0] q_a;
  logic [FW-1:0] q_b;
  logic          sat_a;
  logic          sat_b;

  logic [SW-1:0] m_a;
  logic [SW-1:0] m_b;
  logic [32:0]   num_a;
  logic [32:0]   num_b;
  logic [SW:0]   trial_a;
  logic [SW:0]   trial_b;
  logic          fit_a;
  logic          fit_b;
  logic [FW-1:0] n_a;
  logic [FW-1:0] n_b;
  logic [FW-1:0] diff;

  // A zero maximum is treated as one; numerator is the sample in Q16 plus half the maximum.
  always_comb begin
    m_a = (max_a == '0) ? SW'(1) : max_a;
    m_b = (max_b == '0) ? SW'(1) : max_b;
    num_a = {1'b0, sample_a, 16'b0} + 33'(m_a >> 1);
    num_b = {1'b0, sample_b, 16'b0} + 33'(m_b >> 1);
    trial_a = {rem_a, q_a[FW-1]};
    trial_b = {rem_b, q_b[FW-1]};
    fit_a = trial_a >= {1'b0, div_a};
    fit_b = trial_b >= {1'b0, div_b};
    n_a = sat_a ? rid_pkg::ONE_Q16 : q_a;
    n_b = sat_b ? rid_pkg::ONE_Q16 : q_b;
    diff = (n_a >= n_b) ? (n_a - n_b) : (n_b - n_a);
  end

  // Restoring division, one quotient bit per step; dividend bits shift out as quotient shifts in.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      div_a <= m_a;
      div_b <= m_b;
      sat_a <= sample_a > m_a;
      sat_b <= sample_b > m_b;
      rem_a <= SW'(num_a[32:17]);
      rem_b <= SW'(num_b[32:17]);
      q_a <= num_a[16:0];
      q_b <= num_b[16:0];
    end else if (ctrl.step) begin
      rem_a <= fit_a ? SW'(trial_a - {1'b0, div_a}) : SW'(trial_a);
      rem_b <= fit_b ? SW'(trial_b - {1'b0, div_b}) : SW'(trial_b);
      q_a <= {q_a[FW-2:0], fit_a};
      q_b <= {q_b[FW-2:0], fit_b};
    end
  end

  // Squared difference, registered for the merge stage.
  always_ff @(posedge clk) begin
    if (ctrl.square) begin
      sq <= diff * diff;
    end
  end

endmodule

>>> hdl/rid_root.sv
// Final unit: divides the sum by three times the count, then takes the integer square root.
module rid_root #(
  parameter int MAX_PIXELS_LOG2 = rid_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MAX_PIXELS_LOG2+33:0] sum,
  input  logic [MAX_PIXELS_LOG2:0]    count,
  output logic                        done,
  output logic [rid_pkg::RMS_W-1:0]   root
);

  localparam int SUMW = MAX_PIXELS_LOG2 + 34;
  localparam int DW = MAX_PIXELS_LOG2 + 2;
  localparam int MW = rid_pkg::MEAN_STEPS;
  localparam int RW = rid_pkg::RMS_W;
  localparam int REMW = RW + 2;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_SQRT = 2'd2;

  logic [1:0]      state;
  logic [5:0]      cnt;
  logic [DW-1:0]   divisor;
  logic [DW-1:0]   rem;
  logic [MW-1:0]   q;
  logic [MW:0]     vsh;
  logic [REMW-1:0] srem;

  logic [DW:0]     dtrial;
  logic            dfit;
  logic [REMW+1:0] strial;
  logic [REMW+1:0] sbase;
  logic            sfit;

  always_comb begin
    dtrial = {rem, q[MW-1]};
    dfit = dtrial >= {1'b0, divisor};
    strial = {srem, vsh[MW:MW-1]};
    sbase = (REMW+2)'({root, 2'b01});
    sfit = strial >= sbase;
  end

  // Sequencer over the mean division and the root, one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_DIV;
            cnt <= '0;
          end
        end
        R_DIV: begin
          if (cnt == 6'(MW - 1)) begin
            state <= R_SQRT;
            cnt <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        R_SQRT: begin
          if (cnt == 6'(rid_pkg::ROOT_STEPS - 1)) begin
            state <= R_IDLE;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  // Datapath: restoring division of the sum, then two radicand bits per root step.
  always_ff @(posedge clk) begin
    if (start && state == R_IDLE) begin
      divisor <= DW'({count, 1'b0}) + DW'(count);
      rem <= DW'(sum[SUMW-1:MW]);
      q <= sum[MW-1:0];
    end else if (state == R_DIV) begin
      rem <= dfit ? DW'(dtrial - {1'b0, divisor}) : DW'(dtrial);
      q <= {q[MW-2:0], dfit};
      if (cnt == 6'(MW - 1)) begin
        vsh <= {1'b0, q[MW-2:0], dfit};
        srem <= '0;
        root <= '0;
      end
    end else if (state == R_SQRT) begin
      vsh <= {vsh[MW-2:0], 2'b00};
      srem <= sfit ? REMW'(strial - sbase) : REMW'(strial);
      root <= {root[RW-2:0], sfit};
    end
  end

endmodule
